// ===== hdl/swfd_pkg.sv =====
// Shared types and constants for the sync-word frame deframer.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps

package swfd_pkg;

	// sync word 0x55AA arrives low byte first: 0xAA, then 0x55
	localparam logic [7:0] SYNC_LO = 8'hAA;
	localparam logic [7:0] SYNC_HI = 8'h55;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int RESULT_CAP       = 8;
	localparam int IDX_W            = 3;
	localparam int VAL_W            = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_LO,
		ST_HI,
		ST_PUT
	} seq_state_t;

	// buffer port strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// one decoded channel word
	typedef struct packed {
		logic             last;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] index;
	} chan_word_t;

endpackage

// ===== hdl/swfd_buf.sv =====
// Frame byte buffer: one write port, one read port with registered data.
// Depends on swfd_pkg.
`timescale 1ns / 1ps

module swfd_buf #(
	parameter int DEPTH = 18,
	parameter int AW    = 5
) (
	input  logic               clk,
	input  swfd_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]      wr_addr,
	input  logic [7:0]         wr_data,
	input  logic [AW-1:0]      rd_addr,
	output logic [7:0]         rd_data
);
	import swfd_pkg::*;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/swfd_seq.sv =====
// Sequencer: byte append, sync scan with one shared byte comparator,
// tail shift and channel readout over the single buffer read port.
// Depends on swfd_pkg.
`timescale 1ns / 1ps

module swfd_seq #(
	parameter int NUM_CHANNELS = swfd_pkg::NUM_CHANNELS_DEF,
	parameter int FRAME_BYTES  = 2 + 2 * NUM_CHANNELS,
	parameter int AW           = $clog2(FRAME_BYTES),
	parameter int EMIT_N       = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 out_free,
	output logic                 out_load,
	output swfd_pkg::chan_word_t out_word,
	output swfd_pkg::mem_ctl_t   mem_ctl,
	output logic [AW-1:0]        wr_addr,
	output logic [7:0]           wr_data,
	output logic [AW-1:0]        rd_addr,
	input  logic [7:0]           rd_data
);
	import swfd_pkg::*;

	localparam logic [AW-1:0]    LAST   = AW'(FRAME_BYTES - 1);
	localparam logic [IDX_W-1:0] K_LAST = IDX_W'(EMIT_N - 1);

	seq_state_t       state_q, state_n;
	logic [AW-1:0]    fill_q, fill_n;
	logic [AW-1:0]    idx_q, idx_n;
	logic [AW-1:0]    pos_q, pos_n;
	logic [IDX_W-1:0] k_q, k_n;
	logic [7:0]       prev_q, prev_n;
	logic [7:0]       lo_q, lo_n;
	logic             rd_vld_s1, rd_shift_s1;
	logic [AW-1:0]    rd_addr_s1;
	logic [4:0]       lo_full, hi_full;
	logic             sync_hit;

	assign lo_full  = {1'b0, k_q, 1'b0} + 5'd2;
	assign hi_full  = lo_full + 5'd1;
	// shared comparator: previous byte and current byte against the sync pair
	assign sync_hit = (prev_q == SYNC_LO) && (rd_data == SYNC_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			k_q         <= '0;
			rd_vld_s1   <= 1'b0;
			rd_shift_s1 <= 1'b0;
		end else begin
			state_q     <= state_n;
			fill_q      <= fill_n;
			k_q         <= k_n;
			rd_vld_s1   <= mem_ctl.rd_en;
			rd_shift_s1 <= mem_ctl.rd_en && (state_q == ST_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_n;
		pos_q      <= pos_n;
		prev_q     <= prev_n;
		lo_q       <= lo_n;
		rd_addr_s1 <= rd_addr;
	end

	always_comb begin
		state_n     = state_q;
		fill_n      = fill_q;
		idx_n       = idx_q;
		pos_n       = pos_q;
		k_n         = k_q;
		prev_n      = prev_q;
		lo_n        = lo_q;
		in_ready    = 1'b0;
		out_load    = 1'b0;
		out_word    = '{last: (k_q == K_LAST), value: {rd_data, lo_q}, index: k_q};
		mem_ctl     = '0;
		wr_addr     = fill_q;
		wr_data     = in_byte;
		rd_addr     = idx_q;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mem_ctl.wr_en = 1'b1;
					if (fill_q == LAST) begin
						idx_n   = '0;
						state_n = ST_SCAN;
					end else begin
						fill_n = fill_q + 1'b1;
					end
				end
			end

			ST_SCAN: begin
				mem_ctl.rd_en = 1'b1;
				if (idx_q != LAST) begin
					idx_n = idx_q + 1'b1;
				end
				if (rd_vld_s1) begin
					prev_n = rd_data;
					if (rd_addr_s1 != '0 && sync_hit) begin
						if (rd_addr_s1 == AW'(1)) begin
							k_n     = '0;
							state_n = ST_LO;
						end else begin
							pos_n   = rd_addr_s1 - 1'b1;
							idx_n   = rd_addr_s1 - 1'b1;
							state_n = ST_SHIFT;
						end
					end else if (rd_addr_s1 == LAST) begin
						// no sync pair: keep only the last byte
						pos_n   = LAST;
						idx_n   = LAST;
						state_n = ST_SHIFT;
					end
				end
			end

			ST_SHIFT: begin
				mem_ctl.rd_en = 1'b1;
				if (idx_q != LAST) begin
					idx_n = idx_q + 1'b1;
				end
				if (rd_vld_s1 && rd_shift_s1) begin
					mem_ctl.wr_en = 1'b1;
					wr_addr       = rd_addr_s1 - pos_q;
					wr_data       = rd_data;
					if (rd_addr_s1 == LAST) begin
						fill_n  = wr_addr + 1'b1;
						state_n = ST_IDLE;
					end
				end
			end

			ST_LO: begin
				mem_ctl.rd_en = 1'b1;
				rd_addr       = AW'(lo_full);
				state_n       = ST_HI;
			end

			ST_HI: begin
				mem_ctl.rd_en = 1'b1;
				rd_addr       = AW'(hi_full);
				lo_n          = rd_data;
				state_n       = ST_PUT;
			end

			ST_PUT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (k_q == K_LAST) begin
						fill_n  = '0;
						state_n = ST_IDLE;
					end else begin
						k_n     = k_q + 1'b1;
						state_n = ST_LO;
					end
				end
			end

			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/sync_word_frame_deframer_unit.sv =====
// A byte that does not complete a frame is taken while s_tready stays high.
// A completed frame with the sync word at its head: a scan, then per word two buffer reads
// and a load, for min(NUM_CHANNELS,8) words; a load waits while the output slot is full.
// A completed frame without sync at its head: scan and tail shift, both set by the single
// buffer read port; with no sync pair at all only the last byte is kept.
// Async reset empties the buffer count and output reg.
`timescale 1ns / 1ps

// Top level: byte stream in, decoded channel words out.
// Depends on swfd_pkg, swfd_buf and swfd_seq.
module sync_word_frame_deframer_unit #(
	parameter int NUM_CHANNELS = swfd_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// received byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// decoded channel words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] channel_index, [18:3] channel_value, [23:19] zero
	output logic        m_tlast    // last_channel
);
	import swfd_pkg::*;

	// frame = 2 sync bytes + 2 bytes per channel
	localparam int FRAME_BYTES = 2 + 2 * NUM_CHANNELS;
	localparam int AW          = $clog2(FRAME_BYTES);
	// at most eight words leave per frame
	localparam int EMIT_N      = (NUM_CHANNELS < RESULT_CAP) ? NUM_CHANNELS : RESULT_CAP;

	mem_ctl_t   mem_ctl;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0] wr_data, rd_data;
	logic       out_free, out_load;
	chan_word_t out_word;

	// output word register
	logic       m_tvalid_q;
	chan_word_t word_q;

	swfd_buf #(
		.DEPTH (FRAME_BYTES),
		.AW    (AW)
	) u_buf (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	swfd_seq #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.FRAME_BYTES  (FRAME_BYTES),
		.AW           (AW),
		.EMIT_N       (EMIT_N)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.out_free (out_free),
		.out_load (out_load),
		.out_word (out_word),
		.mem_ctl  (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// slot is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			word_q <= out_word;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, word_q.value, word_q.index};
	assign m_tlast  = word_q.last;

	// words are only produced while the input side is held off
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !s_tready)
		else $error("word loaded while input ready");

	// a pending word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("output word overwritten");

	// the frame-ending word carries the final channel index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[2:0] == 3'(EMIT_N - 1)))
		else $error("tlast on wrong channel index");

endmodule
